// File: src/vpn_pkg.sv
// Shared types and constants of the vector norm unit.
`timescale 1ns / 1ps

package vpn_pkg;

    localparam int ELEM_W = 16;
    localparam int MAG_W  = 17;
    localparam int TERM_W = 31;
    localparam int ACC_W  = 48;
    localparam int NORM_W = 26;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_L1   = 2'd0;
    localparam mode_t MODE_L2   = 2'd1;
    localparam mode_t MODE_MAX  = 2'd2;
    localparam mode_t MODE_ZERO = 2'd3;

    localparam mode_t MODE_RESET = MODE_L2;

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [NORM_W-1:0] NORM_MAX = 26'd33554432;

    // One finished vector handed from the front to the back.
    typedef struct packed {
        mode_t            mode;
        logic [ACC_W-1:0] acc;
    } job_t;

endpackage

// File: src/vector_p_norm_unit.sv
// Top level of the streaming vector norm unit.
`timescale 1ns / 1ps

// Streams a vector of signed Q8.8 elements, one element per item with tlast on the final
// one, and returns one unsigned Q18.8 norm per vector: the sum of magnitudes (mode 0), the
// Euclidean norm (mode 1, floor of the integer root), the largest magnitude (mode 2) or
// zero (mode 3). The running sum saturates at 2^48-1 and the norm at 2^25, so long vectors
// are fine. The front end takes one element per cycle unless the queue is full, through
// a square stage and an accumulate stage. Finished vectors go through a two-entry queue
// to the back end, which forms modes 0, 2 and 3 directly and the Euclidean norm by a
// one-step-per-cycle square root over 24 steps, taking no new vector meanwhile. The mode
// is sampled per element; change it only while the unit is idle. cfg_ready is always high.
module vector_p_norm_unit
    import vpn_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,     // norm_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // [15:0] element
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata       // [25:0] norm, [31:26] zero
);

    logic              fq_valid;
    logic              fq_ready;
    job_t              fq_job;
    logic              qb_valid;
    logic              qb_ready;
    job_t              qb_job;
    logic [NORM_W-1:0] norm;

    vpn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    vpn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    vpn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_norm    (norm)
    );

    assign m_tdata = {6'b0, norm};

endmodule

// File: src/vpn_front.sv
// Front end: takes elements, folds them into the accumulator, hands finished vectors on.
`timescale 1ns / 1ps

module vpn_front
    import vpn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ELEM_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              job_valid,
    input  logic              job_ready,
    output job_t              job
);

    mode_t mode_reg;

    logic              st1_valid_reg;
    logic [TERM_W-1:0] st1_term_reg;
    mode_t             st1_mode_reg;
    logic              st1_last_reg;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_fold;
    logic [ACC_W:0]    acc_sum;

    logic [MAG_W-1:0]   mag;
    logic [2*MAG_W-1:0] square;
    logic [TERM_W-1:0]  term;
    logic               st1_advance;
    logic               s_accept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    // Magnitude of a Q8.8 value; the most negative code maps to 128.0 without wrap.
    always_comb begin
        if (s_tdata[ELEM_W-1]) begin
            mag = 17'h10000 - {1'b0, s_tdata};
        end else begin
            mag = {1'b0, s_tdata};
        end
        square = {{MAG_W{1'b0}}, mag} * {{MAG_W{1'b0}}, mag};
        if (mode_reg == MODE_L2) begin
            term = square[TERM_W-1:0];
        end else begin
            term = {{(TERM_W-MAG_W){1'b0}}, mag};
        end
    end

    assign st1_advance = st1_valid_reg && (!st1_last_reg || job_ready);
    assign s_tready    = !st1_valid_reg || st1_advance;
    assign s_accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_term_reg <= term;
            st1_mode_reg <= mode_reg;
            st1_last_reg <= s_tlast;
        end
    end

    always_comb begin
        acc_sum  = {1'b0, acc_reg} + {{(ACC_W+1-TERM_W){1'b0}}, st1_term_reg};
        acc_fold = acc_reg;
        unique case (st1_mode_reg) inside
            MODE_L1, MODE_L2: begin
                acc_fold = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
            end
            MODE_MAX: begin
                if ({{(ACC_W-TERM_W){1'b0}}, st1_term_reg} > acc_reg) begin
                    acc_fold = {{(ACC_W-TERM_W){1'b0}}, st1_term_reg};
                end
            end
            default: begin
                acc_fold = acc_reg;
            end
        endcase
    end

    // Drop the running sum once the last element has been handed on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (st1_advance) begin
            acc_reg <= st1_last_reg ? '0 : acc_fold;
        end
    end

    assign job_valid = st1_valid_reg && st1_last_reg;
    assign job.mode  = st1_mode_reg;
    assign job.acc   = acc_fold;

endmodule

// File: src/vpn_queue.sv
// Two-entry queue of finished vectors between front and back.
`timescale 1ns / 1ps

module vpn_queue
    import vpn_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: src/vpn_back.sv
// Back end: forms the norm of a queued vector, running the square root bit by bit.
`timescale 1ns / 1ps

module vpn_back
    import vpn_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  job_t              job,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [NORM_W-1:0] m_norm
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ROOT = 1'b1;

    logic              state_reg;
    logic              out_valid_reg;
    logic [NORM_W-1:0] out_norm_reg;

    logic [ACC_W-1:0] rem_reg;
    logic [ACC_W-1:0] res_reg;
    logic [ACC_W-1:0] bit_reg;
    logic [ACC_W-1:0] rem_next;
    logic [ACC_W-1:0] res_next;
    logic [ACC_W-1:0] bit_next;
    logic [ACC_W-1:0] trial;

    logic              out_free;
    logic              take;
    logic              root_done;
    logic [NORM_W-1:0] direct_norm;

    assign out_free  = !out_valid_reg || m_tready;
    assign job_ready = (state_reg == ST_IDLE) && out_free;
    assign take      = job_valid && job_ready;

    // One step of the restoring square root: each step yields one result bit from two radicand bits.
    always_comb begin
        trial    = res_reg + bit_reg;
        bit_next = bit_reg >> 2;
        if (rem_reg >= trial) begin
            rem_next = rem_reg - trial;
            res_next = (res_reg >> 1) + bit_reg;
        end else begin
            rem_next = rem_reg;
            res_next = res_reg >> 1;
        end
    end

    assign root_done = (state_reg == ST_ROOT) && (bit_next == '0);

    always_comb begin
        if (job.mode == MODE_ZERO) begin
            direct_norm = '0;
        end else if (job.acc > {{(ACC_W-NORM_W){1'b0}}, NORM_MAX}) begin
            direct_norm = NORM_MAX;
        end else begin
            direct_norm = job.acc[NORM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (take && job.mode == MODE_L2) begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (root_done) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            rem_reg <= job.acc;
            res_reg <= '0;
            bit_reg <= {2'b01, {(ACC_W-2){1'b0}}};
        end else if (state_reg == ST_ROOT) begin
            rem_reg <= rem_next;
            res_reg <= res_next;
            bit_reg <= bit_next;
        end
    end

    // The root of a 48-bit sum stays below 2^24, so it needs no clamp.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (take && job.mode != MODE_L2) begin
            out_valid_reg <= 1'b1;
        end else if (root_done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && job.mode != MODE_L2) begin
            out_norm_reg <= direct_norm;
        end else if (root_done) begin
            out_norm_reg <= res_next[NORM_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_norm   = out_norm_reg;

endmodule

// File: verif/tb.sv
// Self-checking testbench of the streaming vector norm unit.
`timescale 1ns / 1ps

module tb
    import vpn_pkg::*;
();

    localparam int  SETTLE_CYCLES = 48;       // front stages plus the square root
    localparam int  RANDOM_ITEMS  = 100;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef enum {ROW_MODE, ROW_ELEM} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        mode_t             mode;
        logic [15:0]       elem;
        logic              last;
        int                reps;
        logic              typed;
        logic [NORM_W-1:0] want;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_data;      // norm_mode
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;       // [15:0] element
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;       // [25:0] norm, [31:26] zero

    // Shadow of the unit: mode register and running accumulator
    mode_t             shadow_mode;
    logic [ACC_W-1:0]  shadow_acc;
    logic [NORM_W-1:0] norms_due[$];
    row_t              plan[$];

    int     err_count;
    longint cycle_count;
    int     stall_left;
    logic   ready_steady;

    vector_p_norm_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        $display("ERROR at %0t: %s: got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic logic [MAG_W-1:0] magnitude(input logic [15:0] e);
        return e[15] ? MAG_W'(17'h10000 - {1'b0, e}) : {1'b0, e};
    endfunction

    function automatic logic [23:0] root_floor(input logic [ACC_W-1:0] v);
        logic [23:0] r;
        logic [23:0] t;
        r = '0;
        for (int i = 23; i >= 0; i--) begin
            t = r | (24'd1 << i);
            if (48'(t) * 48'(t) <= v)
                r = t;
        end
        return r;
    endfunction

    // Fold one accepted element into the shadow state; queue the norm on last.
    task automatic fold_element(input logic [15:0] e, input logic l,
                                input logic typed, input logic [NORM_W-1:0] want);
        logic [MAG_W-1:0] mag;
        logic [ACC_W:0]   sum;
        logic [ACC_W-1:0] wide;
        mag = magnitude(e);
        case (shadow_mode)
            MODE_L1: begin
                sum = {1'b0, shadow_acc} + (ACC_W+1)'(mag);
                shadow_acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            end
            MODE_L2: begin
                sum = {1'b0, shadow_acc} + (ACC_W+1)'(mag) * (ACC_W+1)'(mag);
                shadow_acc = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
            end
            MODE_MAX: begin
                if (ACC_W'(mag) > shadow_acc)
                    shadow_acc = ACC_W'(mag);
            end
            default: ;
        endcase
        if (l) begin
            case (shadow_mode) inside
                MODE_L1, MODE_MAX: wide = shadow_acc;
                MODE_L2:           wide = ACC_W'(root_floor(shadow_acc));
                default:           wide = '0;
            endcase
            if (wide > ACC_W'(NORM_MAX))
                wide = ACC_W'(NORM_MAX);
            norms_due.push_back(typed ? want : wide[NORM_W-1:0]);
            shadow_acc = '0;
        end
    endtask

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic logic [15:0] pick_elem();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            4, 5: begin
                v = 16'($urandom_range(0, 1023));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic row_t mk(input row_kind_t k, input mode_t m, input logic [15:0] e,
                                input logic l, input int reps, input logic typed,
                                input logic [NORM_W-1:0] want);
        row_t r;
        r.kind  = k;
        r.mode  = m;
        r.elem  = e;
        r.last  = l;
        r.reps  = reps;
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    task automatic push_elem(input logic [15:0] e, input logic l, input int gap,
                             input logic typed, input logic [NORM_W-1:0] want);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = e;
        s_tlast  = l;
        do @(posedge aclk); while (!s_tready);
        fold_element(e, l, typed, want);
    endtask

    // Drop valid, wait for every pending norm, then let the back stage drain.
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (norms_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input mode_t m);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = m;
        do @(posedge aclk); while (!cfg_ready);
        shadow_mode = m;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Result side: random stalls, with calm stretches now and then
    always @(negedge aclk) begin
        if ($urandom_range(0, 299) == 0)
            ready_steady = ~ready_steady;
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else begin
            m_tready = 1'b1;
            if (!ready_steady && $urandom_range(0, 5) == 0)
                stall_left = gap_cycles() + 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (norms_due.size() == 0) begin
                flag_error("norm with none pending", m_tdata, 32'd0);
            end else begin
                if (m_tdata[NORM_W-1:0] !== norms_due[0])
                    flag_error("norm", 32'(m_tdata[NORM_W-1:0]), 32'(norms_due[0]));
                if (m_tdata[31:NORM_W] !== '0)
                    flag_error("tdata pad bits", 32'(m_tdata[31:NORM_W]), 32'd0);
                void'(norms_due.pop_front());
            end
        end
    end

    initial begin
        int   sent;
        int   span;
        int   odds;
        logic no_gaps;
        logic last_one;
        logic l;

        err_count    = 0;
        cycle_count  = 0;
        stall_left   = 0;
        ready_steady = 1'b0;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        shadow_mode  = MODE_RESET;
        shadow_acc   = '0;

        // Euclidean mode out of reset
        plan.push_back(mk(ROW_ELEM, MODE_L2, 16'h0300, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_L2, 16'h0400, 1'b1, 1, 1'b1, 26'd1280));
        plan.push_back(mk(ROW_ELEM, MODE_L2, 16'h8000, 1'b1, 1, 1'b1, 26'd32768));
        plan.push_back(mk(ROW_ELEM, MODE_L2, 16'h7FFF, 1'b1, 1, 1'b1, 26'd32767));
        plan.push_back(mk(ROW_MODE, MODE_L1, 16'h0000, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_L1, 16'h7FFF, 1'b1, 1, 1'b1, 26'd32767));
        plan.push_back(mk(ROW_ELEM, MODE_L1, 16'h8000, 1'b1, 1, 1'b1, 26'd32768));
        plan.push_back(mk(ROW_ELEM, MODE_L1, 16'h0000, 1'b1, 1, 1'b1, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_L1, 16'hFFFF, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_L1, 16'h0001, 1'b1, 1, 1'b1, 26'd2));
        // vector past the length limit: the norm saturates
        plan.push_back(mk(ROW_ELEM, MODE_L1, 16'h8000, 1'b1, 1025, 1'b1, NORM_MAX));
        plan.push_back(mk(ROW_MODE, MODE_MAX, 16'h0000, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_MAX, 16'hFFFB, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_MAX, 16'h0064, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_MAX, 16'h8000, 1'b1, 1, 1'b1, 26'd32768));
        plan.push_back(mk(ROW_ELEM, MODE_MAX, 16'h0007, 1'b1, 1, 1'b1, 26'd7));
        plan.push_back(mk(ROW_MODE, MODE_ZERO, 16'h0000, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_ZERO, 16'h04D2, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_ZERO, 16'h8000, 1'b1, 1, 1'b1, 26'd0));
        // switch the mode in the middle of a vector
        plan.push_back(mk(ROW_MODE, MODE_L1, 16'h0000, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_L1, 16'h0064, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_MODE, MODE_MAX, 16'h0000, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_MAX, 16'h0032, 1'b1, 1, 1'b1, 26'd100));
        plan.push_back(mk(ROW_MODE, MODE_L2, 16'h0000, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_L2, 16'h1234, 1'b0, 1, 1'b0, 26'd0));
        plan.push_back(mk(ROW_ELEM, MODE_L2, 16'hC3A1, 1'b1, 1, 1'b0, 26'd0));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_MODE) begin
                settle();
                write_mode(plan[i].mode);
            end else begin
                for (int n = 1; n <= plan[i].reps; n++) begin
                    last_one = (n == plan[i].reps);
                    push_elem(plan[i].elem, plan[i].last && last_one,
                              (plan[i].reps > 1) ? 0 : gap_cycles(),
                              plan[i].typed && last_one, plan[i].want);
                end
            end
        end

        // Random phases; a phase may end mid-vector, so the next mode takes over
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            settle();
            write_mode(mode_t'($urandom_range(0, 3)));
            span    = $urandom_range(10, 90);
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 3))
                0:       odds = 2;
                1:       odds = 40;
                default: odds = 6;
            endcase
            for (int n = 0; n < span; n++) begin
                l = ($urandom_range(0, odds - 1) == 0);
                push_elem(pick_elem(), l, no_gaps ? 0 : gap_cycles(), 1'b0, 26'd0);
                sent++;
            end
        end

        settle();
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
